### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/tsp_pkg.sv
package tsp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIST_W     = 32;
  localparam int SPD_W      = 24;
  localparam int PROD_W     = DIST_W + SPD_W;
  localparam int TWO_AT_W   = PROD_W + 1;
  localparam int SQR_W      = 2 * SPD_W;
  localparam int RAD_W      = TWO_AT_W + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 5;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(SQRT_STEPS);
  localparam int PHASE_W    = 2;
  localparam int ADDR_W     = 5;
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 32;

  localparam logic [SPD_W-1:0] SPEED_ONE = SPD_W'(1) << FRAC_BITS;

  localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

  localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [IDX_W-1:0] REG_VMAX   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ACCEL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_EXIT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ENTRY  = 3'd4;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [DIST_W-1:0]   t;
    logic [SPD_W-1:0]    a;
    logic [SPD_W-1:0]    x;
    logic [SPD_W-1:0]    peak;
    logic                triang;
    logic [TWO_AT_W-1:0] two_at;
    logic [SQR_W-1:0]    v2;
    logic [SQR_W-1:0]    x2;
    logic [SQR_W-1:0]    e2;
    logic [SQR_W-1:0]    p2;
  } prof_t;

  // one restoring root digit
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] bits);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    sqrt_st_t         o;
    r     = {s.rem[REM_W-3:0], bits};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### hdl/tsp_query_pipe.sv
`include "assert_macros.svh"

module tsp_query_pipe (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic signed [tsp_pkg::DIST_W-1:0]  position_i,
  input  tsp_pkg::prof_t                     prof_i,
  output logic                               valid_o,
  output logic [tsp_pkg::SPD_W-1:0]          speed_o,
  output logic [tsp_pkg::PHASE_W-1:0]        phase_o,
  output logic                               complete_o
);
  import tsp_pkg::*;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               cmpl;
    logic [RAD_W-1:0]   rad;
    sqrt_st_t           st;
  } sq_stage_t;

  function automatic sq_stage_t sq_adv(sq_stage_t s);
    sq_stage_t o;
    o     = s;
    o.rad = s.rad << 2;
    o.st  = sqrt_step(s.st, s.rad[RAD_W-1 -: 2]);
    return o;
  endfunction

  logic                pos_neg;
  logic [DIST_W-1:0]   pos_u;
  logic [DIST_W-1:0]   pos_c;
  logic                cmpl_c;

  logic                vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;
  logic [DIST_W-1:0]   pos1_q;
  logic                done1_q, done2_q, done3_q, done4_q;
  logic                cmpl1_q, cmpl2_q, cmpl3_q, cmpl4_q;
  logic [PROD_W-1:0]   m2_q;
  logic [TWO_AT_W-1:0] ap2;
  logic [RAD_W-1:0]    s0_3_q, s0_4_q, s2_4_q;
  logic [TWO_AT_W-1:0] rest3_q;
  logic                ph0_4_q;
  sq_stage_t           s5_q;
  logic [PHASE_W-1:0]  phase5;

  logic [SQRT_STEPS-1:0] sq_vld_q;
  sq_stage_t             sq_q [SQRT_STEPS];
  sq_stage_t             last;
  logic [SPD_W-1:0]      speed_c;

  logic                valid_q;
  logic [SPD_W-1:0]    speed_q;
  logic [PHASE_W-1:0]  phase_q;
  logic                cmpl_q;

  // clamp to the move
  assign pos_neg = position_i[DIST_W-1];
  assign pos_u   = position_i;
  assign cmpl_c  = !pos_neg && (pos_u >= prof_i.t);
  assign pos_c   = pos_neg ? '0 : ((pos_u > prof_i.t) ? prof_i.t : pos_u);

  assign ap2 = {m2_q, 1'b0};

  always_comb begin
    if (done4_q) begin
      phase5 = PH_DONE;
    end else if (ph0_4_q) begin
      phase5 = PH_ACCEL;
    end else if (!prof_i.triang && (s2_4_q > RAD_W'(prof_i.v2))) begin
      phase5 = PH_CRUISE;
    end else begin
      phase5 = PH_DECEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q   <= 1'b0;
      vld2_q   <= 1'b0;
      vld3_q   <= 1'b0;
      vld4_q   <= 1'b0;
      vld5_q   <= 1'b0;
      sq_vld_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      vld1_q   <= in_valid_i;
      vld2_q   <= vld1_q;
      vld3_q   <= vld2_q;
      vld4_q   <= vld3_q;
      vld5_q   <= vld4_q;
      sq_vld_q <= {sq_vld_q[SQRT_STEPS-2:0], vld5_q};
      valid_q  <= sq_vld_q[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pos1_q  <= pos_c;
    done1_q <= (pos_c == prof_i.t);
    cmpl1_q <= cmpl_c;

    m2_q    <= {{DIST_W{1'b0}}, prof_i.a} * {{SPD_W{1'b0}}, pos1_q};
    done2_q <= done1_q;
    cmpl2_q <= cmpl1_q;

    s0_3_q  <= {1'b0, ap2} + RAD_W'(prof_i.e2);
    rest3_q <= prof_i.two_at - ap2;
    done3_q <= done2_q;
    cmpl3_q <= cmpl2_q;

    s0_4_q  <= s0_3_q;
    ph0_4_q <= s0_3_q < RAD_W'(prof_i.p2);
    s2_4_q  <= RAD_W'(prof_i.x2) + {1'b0, rest3_q};
    done4_q <= done3_q;
    cmpl4_q <= cmpl3_q;

    s5_q.phase <= phase5;
    s5_q.cmpl  <= cmpl4_q;
    s5_q.rad   <= ph0_4_q ? s0_4_q : s2_4_q;
    s5_q.st    <= '0;

    sq_q[0] <= sq_adv(s5_q);
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sq_q[k] <= sq_adv(sq_q[k-1]);
    end

    speed_q <= speed_c;
    phase_q <= last.phase;
    cmpl_q  <= last.cmpl;
  end

  assign last = sq_q[SQRT_STEPS-1];

  always_comb begin
    case (last.phase)
      PH_DONE:   speed_c = prof_i.x;
      PH_CRUISE: speed_c = prof_i.peak;
      default: begin
        if (last.st.root > ROOT_W'(prof_i.peak)) begin
          speed_c = prof_i.peak;
        end else begin
          speed_c = last.st.root[SPD_W-1:0];
        end
      end
    endcase
  end

  assign valid_o    = valid_q;
  assign speed_o    = speed_q;
  assign phase_o    = phase_q;
  assign complete_o = cmpl_q;

  `ASSERT_IMPL(a_speed_within_peak, valid_o && (phase_o != PH_DONE), speed_o <= prof_i.peak)
  `ASSERT_IMPL(a_complete_is_done, valid_o && complete_o, phase_o == PH_DONE)
  `ASSERT_IMPL(a_cruise_at_peak, valid_o && (phase_o == PH_CRUISE), speed_o == prof_i.peak)

endmodule

### hdl/trapezoidal_speed_profile.sv
// Position-based trapezoidal/triangular speed profile. Each accepted request (start high
// while busy is low) gives exactly one result on speed_o, phase_o, complete_o,
// triangular_o and peak_o, marked by valid_o for one cycle; a new request may be accepted
// every cycle while busy stays low, and the receiver cannot stall the results. Each
// result passes the clamp, multiply and compare stages and then the 29-stage root
// pipeline. After reset and after every register write, busy stays high while the
// entry limit, peak and squared terms are recomputed through one shared multiplier and
// a one-digit-per-cycle root unit.
`include "assert_macros.svh"

module trapezoidal_speed_profile (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tsp_pkg::DIST_W-1:0]  position_i,
  output logic                               valid_o,
  output logic [tsp_pkg::SPD_W-1:0]          speed_o,
  output logic [tsp_pkg::PHASE_W-1:0]        phase_o,
  output logic                               complete_o,
  output logic                               triangular_o,
  output logic [tsp_pkg::SPD_W-1:0]          peak_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsp_pkg::ADDR_W-1:0]         paddr,
  input  logic [tsp_pkg::DATA_W-1:0]         pwdata,
  output logic [tsp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import tsp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AT   = 4'd1;
  localparam logic [3:0] ST_V2   = 4'd2;
  localparam logic [3:0] ST_X2   = 4'd3;
  localparam logic [3:0] ST_E2   = 4'd4;
  localparam logic [3:0] ST_FEAS = 4'd5;
  localparam logic [3:0] ST_SQRT = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_TRAP = 4'd8;
  localparam logic [3:0] ST_P2   = 4'd9;

  logic [DIST_W-1:0] target_q;
  logic [SPD_W-1:0]  vmax_q, accel_q, exit_q, entry_q;
  logic              cfg_wr;
  logic [IDX_W-1:0]  cfg_idx;

  logic [3:0]          state_q, state_d;
  logic [STEP_W-1:0]   cnt_q;
  logic                sel_peak_q;
  logic [TWO_AT_W-1:0] two_at_q;
  logic [SQR_W-1:0]    v2_q, x2_q, e2_q, p2_q;
  logic [SPD_W-1:0]    e_q, peak_q;
  logic                tri_q;
  logic [RAD_W-1:0]    sum_q, rad_q;
  sqrt_st_t            sqs_q;
  sqrt_st_t            sq_next;
  logic                sq_last;

  logic [SPD_W-1:0]  a_eff;
  logic [SPD_W-1:0]  mul_a;
  logic [DIST_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [RAD_W-1:0]  feas_sum;
  logic              feas;
  logic              trap;
  logic              in_valid;
  prof_t             prof;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      vmax_q   <= SPEED_ONE;
      accel_q  <= SPEED_ONE;
      exit_q   <= '0;
      entry_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET: target_q <= pwdata;
        REG_VMAX:   vmax_q   <= pwdata[SPD_W-1:0];
        REG_ACCEL:  accel_q  <= pwdata[SPD_W-1:0];
        REG_EXIT:   exit_q   <= pwdata[SPD_W-1:0];
        REG_ENTRY:  entry_q  <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET: prdata = target_q;
      REG_VMAX:   prdata = DATA_W'(vmax_q);
      REG_ACCEL:  prdata = DATA_W'(accel_q);
      REG_EXIT:   prdata = DATA_W'(exit_q);
      REG_ENTRY:  prdata = DATA_W'(entry_q);
      default:    prdata = '0;
    endcase
  end

  // profile derivation
  assign a_eff = (accel_q == '0) ? SPD_W'(1) : accel_q;

  always_comb begin
    unique case (state_q)
      ST_AT: begin
        mul_a = a_eff;
        mul_b = target_q;
      end
      ST_V2: begin
        mul_a = vmax_q;
        mul_b = DIST_W'(vmax_q);
      end
      ST_X2: begin
        mul_a = exit_q;
        mul_b = DIST_W'(exit_q);
      end
      ST_E2: begin
        mul_a = e_q;
        mul_b = DIST_W'(e_q);
      end
      ST_P2: begin
        mul_a = peak_q;
        mul_b = DIST_W'(peak_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = {{DIST_W{1'b0}}, mul_a} * {{SPD_W{1'b0}}, mul_b};
  assign feas_sum = {1'b0, two_at_q} + RAD_W'(x2_q);
  assign feas     = feas_sum < RAD_W'(e2_q);
  assign trap     = RAD_W'({v2_q, 1'b0}) <= sum_q;
  assign sq_next  = sqrt_step(sqs_q, rad_q[RAD_W-1 -: 2]);
  assign sq_last  = cnt_q == STEP_W'(SQRT_STEPS - 1);

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_AT:   state_d = ST_V2;
      ST_V2:   state_d = ST_X2;
      ST_X2:   state_d = ST_E2;
      ST_E2:   state_d = ST_FEAS;
      ST_FEAS: state_d = feas ? ST_SQRT : ST_SUM;
      ST_SQRT: state_d = sq_last ? (sel_peak_q ? ST_P2 : ST_E2) : ST_SQRT;
      ST_SUM:  state_d = ST_TRAP;
      ST_TRAP: state_d = trap ? ST_P2 : ST_SQRT;
      ST_P2:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (cfg_wr) begin
      state_d = ST_AT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_AT;
      cnt_q      <= '0;
      sel_peak_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FEAS) begin
        cnt_q      <= '0;
        sel_peak_q <= 1'b0;
      end else if (state_q == ST_TRAP) begin
        cnt_q      <= '0;
        sel_peak_q <= 1'b1;
      end else if (state_q == ST_SQRT) begin
        cnt_q <= cnt_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_AT: begin
        two_at_q <= {prod, 1'b0};
        e_q      <= (entry_q < vmax_q) ? entry_q : vmax_q;
      end
      ST_V2: v2_q <= prod[SQR_W-1:0];
      ST_X2: x2_q <= prod[SQR_W-1:0];
      ST_E2: e2_q <= prod[SQR_W-1:0];
      ST_FEAS: begin
        rad_q <= feas_sum;
        sqs_q <= '0;
      end
      ST_SQRT: begin
        rad_q <= rad_q << 2;
        sqs_q <= sq_next;
        if (sq_last) begin
          if (sel_peak_q) begin
            peak_q <= (sq_next.root < ROOT_W'(exit_q)) ? exit_q : sq_next.root[SPD_W-1:0];
          end else begin
            e_q <= sq_next.root[SPD_W-1:0];
          end
        end
      end
      ST_SUM: sum_q <= {1'b0, two_at_q} + RAD_W'(e2_q) + RAD_W'(x2_q);
      ST_TRAP: begin
        sqs_q <= '0;
        rad_q <= sum_q >> 1;
        if (trap) begin
          tri_q  <= 1'b0;
          peak_q <= vmax_q;
        end else begin
          tri_q <= 1'b1;
        end
      end
      ST_P2: p2_q <= prod[SQR_W-1:0];
      default: ;
    endcase
  end

  assign busy     = state_q != ST_IDLE;
  assign in_valid = start && !busy;

  always_comb begin
    prof.t      = target_q;
    prof.a      = a_eff;
    prof.x      = exit_q;
    prof.peak   = peak_q;
    prof.triang = tri_q;
    prof.two_at = two_at_q;
    prof.v2     = v2_q;
    prof.x2     = x2_q;
    prof.e2     = e2_q;
    prof.p2     = p2_q;
  end

  tsp_query_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .position_i (position_i),
    .prof_i     (prof),
    .valid_o    (valid_o),
    .speed_o    (speed_o),
    .phase_o    (phase_o),
    .complete_o (complete_o)
  );

  assign triangular_o = tri_q;
  assign peak_o       = peak_q;

  `ASSERT_IMPL(a_entry_feasible, state_q == ST_IDLE, !feas)
  `ASSERT_IMPL(a_trap_peak_is_limit, (state_q == ST_IDLE) && !tri_q, peak_q == vmax_q)
  `ASSERT_NEXT(a_quiet_stays_free, start && !busy && !cfg_wr, !busy)

endmodule

### tb/sv/tb_trapezoidal_speed_profile.sv
module tb_trapezoidal_speed_profile;
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [SPD_W-1:0]   speed;
    logic [PHASE_W-1:0] phase;
    logic               complete;
    logic               triang;
    logic [SPD_W-1:0]   peak;
  } motion_t;

  class profile_board;
    longint unsigned dist_t, vmax, acc, vexit, ventry;
    motion_t pending[$];
    int errors, checked, done_hits, tri_hits, cruise_hits;

    function new();
      dist_t = 0; vmax = 64'd1 << FRAC_BITS; acc = 64'd1 << FRAC_BITS; vexit = 0; ventry = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        REG_TARGET: dist_t = 64'(d);
        REG_VMAX:   vmax = 64'(d[SPD_W-1:0]);
        REG_ACCEL:  acc = 64'(d[SPD_W-1:0]);
        REG_EXIT:   vexit = 64'(d[SPD_W-1:0]);
        REG_ENTRY:  ventry = 64'(d[SPD_W-1:0]);
        default: ;
      endcase
    endfunction

    static function longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note(logic signed [DIST_W-1:0] position);
      longint unsigned a, e, two_at, v2, x2, e2, pk, p2, p, spd;
      longint sp;
      bit tri_mv;
      motion_t m;
      a = (acc == 0) ? 1 : acc;
      e = (ventry < vmax) ? ventry : vmax;
      two_at = 2 * a * dist_t;
      v2 = vmax * vmax;
      x2 = vexit * vexit;
      e2 = e * e;
      if (longint'(two_at) < longint'(e2) - longint'(x2)) begin
        e = root_floor(x2 + two_at);
        e2 = e * e;
      end
      if (2 * longint'(v2) - longint'(e2) - longint'(x2) <= longint'(two_at)) begin
        tri_mv = 0;
        pk = vmax;
      end else begin
        tri_mv = 1;
        pk = root_floor((two_at + e2 + x2) >> 1);
        if (pk < vexit) pk = vexit;
      end
      p2 = pk * pk;
      sp = longint'(position);
      m.complete = sp >= longint'(dist_t);
      p = (sp < 0) ? 0 : sp;
      if (p > dist_t) p = dist_t;
      if (p >= dist_t) begin
        spd = vexit;
        m.phase = PH_DONE;
      end else if (longint'(2 * a * p) < longint'(p2) - longint'(e2)) begin
        spd = root_floor(e2 + 2 * a * p);
        if (spd > pk) spd = pk;
        m.phase = PH_ACCEL;
      end else if (!tri_mv &&
                   longint'(2 * a * (dist_t - p)) > longint'(v2) - longint'(x2)) begin
        spd = pk;
        m.phase = PH_CRUISE;
      end else begin
        spd = root_floor(x2 + 2 * a * (dist_t - p));
        if (spd > pk) spd = pk;
        m.phase = PH_DECEL;
      end
      m.speed = spd[SPD_W-1:0];
      m.triang = tri_mv;
      m.peak = pk[SPD_W-1:0];
      if (m.phase == PH_DONE) done_hits++;
      if (m.phase == PH_CRUISE) cruise_hits++;
      if (tri_mv) tri_hits++;
      pending.push_back(m);
    endfunction

    function void check(motion_t got);
      motion_t w;
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      if (got.speed !== w.speed) begin
        $display("%0t: speed expected %h actual %h", $time, w.speed, got.speed);
        errors++;
      end
      if (got.phase !== w.phase) begin
        $display("%0t: phase expected %0d actual %0d", $time, w.phase, got.phase);
        errors++;
      end
      if (got.complete !== w.complete) begin
        $display("%0t: complete expected %b actual %b", $time, w.complete, got.complete);
        errors++;
      end
      if (got.triang !== w.triang) begin
        $display("%0t: triangular expected %b actual %b", $time, w.triang, got.triang);
        errors++;
      end
      if (got.peak !== w.peak) begin
        $display("%0t: peak expected %h actual %h", $time, w.peak, got.peak);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 0;
  logic                       rst_ni = 0;
  logic                       start = 0;
  logic                       busy;
  logic signed [DIST_W-1:0]   position_i = '0;
  logic                       valid_o;
  logic [SPD_W-1:0]           speed_o;
  logic [PHASE_W-1:0]         phase_o;
  logic                       complete_o;
  logic                       triangular_o;
  logic [SPD_W-1:0]           peak_o;
  logic                       psel = 0;
  logic                       penable = 0;
  logic                       pwrite = 0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  profile_board board = new();
  int cycles = 0;
  int n_req = 0;

  trapezoidal_speed_profile DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("trapezoidal_speed_profile test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    motion_t r;
    if (rst_ni && valid_o) begin
      r.speed = speed_o;
      r.phase = phase_o;
      r.complete = complete_o;
      r.triang = triangular_o;
      r.peak = peak_o;
      board.check(r);
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= d;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    board.write_reg(idx, d);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic setup_move(logic [31:0] t, logic [23:0] v, logic [23:0] a,
                            logic [23:0] x, logic [23:0] e);
    drain();
    reg_write(REG_TARGET, t);
    reg_write(REG_VMAX, DATA_W'(v));
    reg_write(REG_ACCEL, DATA_W'(a));
    reg_write(REG_EXIT, DATA_W'(x));
    reg_write(REG_ENTRY, DATA_W'(e));
  endtask

  task automatic send(logic signed [DIST_W-1:0] position, int gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1;
    position_i <= position;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note(position);
    n_req++;
  endtask

  function automatic logic [31:0] scaled(int w);
    logic [31:0] r;
    r = $urandom;
    if (w < 32) r = r & ((32'd1 << w) - 1);
    return r >> $urandom_range(0, w - 1);
  endfunction

  function automatic logic [31:0] pick_pos(logic [31:0] t);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return t + $urandom_range(0, 2) - 1;
      2: return -$urandom_range(0, 255);
      default: return (t == 0) ? 32'd0 : 32'({$urandom, $urandom} % (64'(t) + 64'd1));
    endcase
  endfunction

  task automatic probe(int burst);
    logic [31:0] t;
    t = 32'(board.dist_t);
    send(0, 0); send(-1, 1); send(32'h8000_0000, 0); send(32'h7fff_ffff, 2);
    send(t, 0); send(t - 1, 0); send(t + 1, 3); send(t >> 1, 0);
    send(1, 0); send(t >> 2, 0);
    for (int i = 0; i < burst; i++) send(pick_pos(t), 0);
  endtask

  initial begin
    int gapmode;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    probe(0);
    setup_move(32'h0005_0000, 24'h02_0000, 24'h01_0000, 24'h00_8000, 24'h01_0000);
    probe(0);
    setup_move(32'h0000_8000, 24'h08_0000, 24'h00_0000, 24'h03_0000, 24'hff_ffff);
    probe(0);
    setup_move(32'h0000_0000, 24'hff_ffff, 24'hff_ffff, 24'hff_ffff, 24'hff_ffff);
    reg_write(REG_SPARE, 32'h1234_5678);
    probe(0);
    setup_move(32'hffff_ffff, 24'hff_ffff, 24'hff_ffff, 24'hff_ffff, 24'h00_0000);
    probe(2);
    setup_move(32'h0010_0000, 24'h01_0000, 24'h00_4000, 24'h04_0000, 24'h00_8000);
    probe(2);
    setup_move(32'hffff_ffff, 24'h00_0001, 24'h00_0001, 24'h00_0000, 24'h00_0001);
    probe(2);
    for (int ph = 0; ph < 14; ph++) begin
      setup_move(scaled(32), 24'(scaled(24)), 24'(scaled(24)), 24'(scaled(24)),
                 24'(scaled(24)));
      for (int i = 0; i < 110; i++) begin
        gapmode = (i / 30) % 2;
        if (i == 55) begin
          start <= 0;
          @(posedge clk_i);
          while (board.pending.size() != 0) @(posedge clk_i);
        end
        send(pick_pos(32'(board.dist_t)), gapmode ? $urandom_range(0, 11) : 0);
      end
    end
    start <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("%0d requests, %0d results checked: %0d triangular, %0d cruise, %0d done",
             n_req, board.checked, board.tri_hits, board.cruise_hits, board.done_hits);
    if (board.errors == 0) begin
      $display("trapezoidal_speed_profile test passed");
    end else begin
      $display("trapezoidal_speed_profile test failed");
    end
    $finish;
  end

endmodule
